// File: rtl/core/susp_pkg.sv
// Shared types and constants for the spreadsheet unicode string parser.
// No dependencies; susp_step, susp_out_stage and the top level in rtl/core refer to this package.
package susp_pkg;

	// Bit positions in the string flag byte
	localparam int unsigned FLAG_WIDE_BIT = 0;
	localparam int unsigned FLAG_EXT_BIT  = 2;
	localparam int unsigned FLAG_RICH_BIT = 3;

	// Each rich run adds four skipped bytes: shift the run count left by two
	localparam int unsigned RUN_SKIP_SHIFT = 2;

	localparam int unsigned CHAR_W  = 16;
	localparam int unsigned SKIP_W  = 33;
	localparam int unsigned FIELD_W = 24;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_LEN_HI = 7'b0000010,
		PH_FLAGS  = 7'b0000100,
		PH_RUNS   = 7'b0001000,
		PH_EXT    = 7'b0010000,
		PH_CHARS  = 7'b0100000,
		PH_SKIP   = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [CHAR_W-1:0]   char_target;
		logic [CHAR_W-1:0]   char_count_read;
		logic                wide_chars;
		logic                ext_present;
		logic [15:0]         rich_run_count;
		logic [SKIP_W-1:0]   skip_left;
		logic [1:0]          field_byte_index;
		logic [FIELD_W-1:0]  partial_field;
	} parse_state_t;

	typedef struct packed {
		logic              valid;
		logic              char_valid;
		logic [CHAR_W-1:0] char_code;
		logic              string_done;
	} result_t;

endpackage

// File: rtl/core/susp_ifs.sv
// Request and result channel interfaces for the string parser.
// Depends on: nothing.
interface susp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       record_start;
	logic       len_two_bytes;

	modport source (output valid, data_byte, record_start, len_two_bytes, input ready);
	modport sink (input valid, data_byte, record_start, len_two_bytes, output ready);
endinterface

interface susp_char_if;
	logic        valid;
	logic        ready;
	logic        char_valid;
	logic [15:0] char_code;
	logic        string_done;

	modport source (output valid, char_valid, char_code, string_done, input ready);
	modport sink (input valid, char_valid, char_code, string_done, output ready);
endinterface

// File: rtl/core/susp_in_stage.sv
// Input register stage: holds one accepted byte request until the step logic takes it.
// Depends on: susp_ifs.sv (susp_byte_if).
module susp_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	susp_byte_if.sink     byte_req,
	input  logic          out_free,
	output logic          valid_s1,
	output logic [7:0]    data_byte_s1,
	output logic          record_start_s1,
	output logic          len_two_bytes_s1
);

	logic accept;

	// take a new request when empty or when the held one advances this cycle
	assign byte_req.ready = !valid_s1 || out_free;
	assign accept         = byte_req.valid && byte_req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (out_free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_byte_s1     <= byte_req.data_byte;
			record_start_s1  <= byte_req.record_start;
			len_two_bytes_s1 <= byte_req.len_two_bytes;
		end
	end

endmodule

// File: rtl/core/susp_step.sv
// Parser step: the phase register, counters and field assembly, plus the
// combinational update for one byte. Depends on: susp_pkg.
module susp_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              byte_order,
	input  logic [7:0]        data_byte,
	input  logic              record_start,
	input  logic              len_two_bytes,
	output susp_pkg::result_t res
);

	susp_pkg::parse_state_t st_q;
	susp_pkg::parse_state_t nx;

	logic [23:0]                   collected;
	logic [15:0]                   fin2;
	logic [31:0]                   fin4;
	logic [31:0]                   le_shift;
	logic                          go_body;
	logic [31:0]                   ext_val;
	logic [15:0]                   runs_val;
	logic [susp_pkg::SKIP_W-1:0]   skip_sum;
	logic [susp_pkg::SKIP_W-1:0]   skip_dec;
	logic [susp_pkg::CHAR_W-1:0]   cnt_inc;
	logic [susp_pkg::CHAR_W-1:0]   code;

	// field assembly in either byte order
	assign le_shift  = {24'd0, data_byte} << {st_q.field_byte_index, 3'b000};
	assign collected = byte_order ? {st_q.partial_field[15:0], data_byte}
	                              : (st_q.partial_field | le_shift[23:0]);
	assign fin2      = byte_order ? {st_q.partial_field[7:0], data_byte}
	                              : ({data_byte, 8'd0} | st_q.partial_field[15:0]);
	assign fin4      = byte_order ? {st_q.partial_field, data_byte}
	                              : ({data_byte, 24'd0} | {8'd0, st_q.partial_field});

	assign skip_sum = {1'b0, ext_val}
		+ {15'd0, runs_val, {susp_pkg::RUN_SKIP_SHIFT{1'b0}}};
	assign skip_dec = st_q.skip_left - {32'd0, (st_q.skip_left != '0)};
	assign cnt_inc  = st_q.char_count_read + 16'd1;

	always_comb begin
		nx       = st_q;
		res      = '0;
		go_body  = 1'b0;
		ext_val  = '0;
		runs_val = st_q.rich_run_count;
		code     = {8'd0, data_byte};
		case (st_q.phase)
			susp_pkg::PH_LEN_HI: begin
				nx.char_target      = fin2;
				nx.field_byte_index = '0;
				nx.partial_field    = '0;
				nx.phase            = susp_pkg::PH_FLAGS;
			end
			susp_pkg::PH_FLAGS: begin
				nx.wide_chars       = data_byte[susp_pkg::FLAG_WIDE_BIT];
				nx.ext_present      = data_byte[susp_pkg::FLAG_EXT_BIT];
				nx.field_byte_index = '0;
				nx.partial_field    = '0;
				if (data_byte[susp_pkg::FLAG_RICH_BIT]) begin
					nx.phase = susp_pkg::PH_RUNS;
				end else if (data_byte[susp_pkg::FLAG_EXT_BIT]) begin
					nx.phase = susp_pkg::PH_EXT;
				end else begin
					go_body = 1'b1;
				end
			end
			susp_pkg::PH_RUNS: begin
				if (st_q.field_byte_index == 2'd0) begin
					nx.partial_field    = collected;
					nx.field_byte_index = st_q.field_byte_index + 2'd1;
				end else begin
					nx.rich_run_count   = fin2;
					runs_val            = fin2;
					nx.field_byte_index = '0;
					nx.partial_field    = '0;
					if (st_q.ext_present) begin
						nx.phase = susp_pkg::PH_EXT;
					end else begin
						go_body = 1'b1;
					end
				end
			end
			susp_pkg::PH_EXT: begin
				if (st_q.field_byte_index != 2'd3) begin
					nx.partial_field    = collected;
					nx.field_byte_index = st_q.field_byte_index + 2'd1;
				end else begin
					ext_val = fin4;
					go_body = 1'b1;
				end
			end
			susp_pkg::PH_CHARS: begin
				if (record_start) begin
					// option byte of a continuation record: reload width, drop a half character
					nx.wide_chars       = data_byte[susp_pkg::FLAG_WIDE_BIT];
					nx.field_byte_index = '0;
					nx.partial_field    = '0;
				end else if (st_q.wide_chars && st_q.field_byte_index == 2'd0) begin
					nx.partial_field    = collected;
					nx.field_byte_index = st_q.field_byte_index + 2'd1;
				end else begin
					if (st_q.wide_chars) begin
						code = fin2;
					end
					nx.field_byte_index = '0;
					nx.partial_field    = '0;
					nx.char_count_read  = cnt_inc;
					res.valid           = 1'b1;
					res.char_valid      = 1'b1;
					res.char_code       = code;
					if (cnt_inc == st_q.char_target) begin
						if (st_q.skip_left != '0) begin
							nx.phase = susp_pkg::PH_SKIP;
						end else begin
							nx.phase        = susp_pkg::PH_IDLE;
							res.string_done = 1'b1;
						end
					end
				end
			end
			susp_pkg::PH_SKIP: begin
				nx.skip_left = skip_dec;
				if (skip_dec == '0) begin
					nx.phase        = susp_pkg::PH_IDLE;
					res.valid       = 1'b1;
					res.string_done = 1'b1;
				end
			end
			default: begin
				// idle: this byte opens a new string header
				nx.char_count_read  = '0;
				nx.wide_chars       = 1'b0;
				nx.ext_present      = 1'b0;
				nx.rich_run_count   = '0;
				nx.skip_left        = '0;
				nx.field_byte_index = '0;
				nx.partial_field    = '0;
				if (len_two_bytes) begin
					nx.char_target      = '0;
					nx.partial_field    = {16'd0, data_byte};
					nx.field_byte_index = 2'd1;
					nx.phase            = susp_pkg::PH_LEN_HI;
				end else begin
					nx.char_target = {8'd0, data_byte};
					nx.phase       = susp_pkg::PH_FLAGS;
				end
			end
		endcase

		if (go_body) begin
			nx.skip_left        = skip_sum;
			nx.field_byte_index = '0;
			nx.partial_field    = '0;
			if (st_q.char_target != '0) begin
				nx.phase = susp_pkg::PH_CHARS;
			end else if (skip_sum != '0) begin
				nx.phase = susp_pkg::PH_SKIP;
			end else begin
				nx.phase        = susp_pkg::PH_IDLE;
				res.valid       = 1'b1;
				res.string_done = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// phase is the leading field: idle, everything else cleared
			st_q <= {susp_pkg::PH_IDLE,
				{($bits(susp_pkg::parse_state_t) - $bits(susp_pkg::phase_t)){1'b0}}};
		end else if (fire) begin
			st_q <= nx;
		end
	end

endmodule

// File: rtl/core/susp_out_stage.sv
// Result register: holds one result until the consumer takes it.
// Depends on: susp_pkg, susp_ifs.sv (susp_char_if).
module susp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  susp_pkg::result_t res,
	susp_char_if.source       char_res,
	output logic              out_free
);

	logic        out_valid_q;
	logic        char_valid_q;
	logic [15:0] char_code_q;
	logic        string_done_q;

	assign out_free = !out_valid_q || char_res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (char_res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res.valid) begin
			char_valid_q  <= res.char_valid;
			char_code_q   <= res.char_code;
			string_done_q <= res.string_done;
		end
	end

	assign char_res.valid       = out_valid_q;
	assign char_res.char_valid  = char_valid_q;
	assign char_res.char_code   = char_code_q;
	assign char_res.string_done = string_done_q;

endmodule

// File: rtl/core/spreadsheet_unicode_string_parser_core.sv
// Top level of the spreadsheet unicode string parser.
// Depends on: susp_pkg, susp_ifs.sv, susp_in_stage, susp_step, susp_out_stage.
//
// Byte-serial parser for rich/extended unicode strings in spreadsheet record
// streams. Each request on byte_req carries one payload byte; a byte taken while
// the parser is idle opens a string header (one- or two-byte character count
// chosen by len_two_bytes, then a flag byte). Characters come out on char_res,
// 8-bit ones zero extended; extension and rich-run bytes are skipped, and the
// last result of every string has string_done set (a result with char_valid low
// marks the end of a string that finishes without a character on that byte).
// A request with record_start set while characters remain is taken as a
// continuation option byte and reloads the character width. The block takes
// one request per clock while the result register can advance: a request is
// registered in the input register on acceptance, then decoded by the step
// logic, which loads the result register that drives char_res. The one-entry
// result register is the only place that can stall: a new request is
// accepted whenever the input register is empty or its byte can advance,
// which is every cycle the consumer keeps ready high. byte_order (cfg_wdata,
// written with cfg_we) picks little (0) or big (1) endian for all multi-byte
// fields; write it only while the parser is idle.
module spreadsheet_unicode_string_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	susp_byte_if.sink   byte_req,
	susp_char_if.source char_res,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	logic              byte_order_q;
	logic              valid_s1;
	logic [7:0]        data_byte_s1;
	logic              record_start_s1;
	logic              len_two_bytes_s1;
	logic              out_free;
	logic              step_fire;
	susp_pkg::result_t step_res;

	// configuration: single byte order bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_order_q <= 1'b0;
		end else if (cfg_we) begin
			byte_order_q <= cfg_wdata;
		end
	end

	// hold the accepted request
	susp_in_stage u_in (
		.clk              (clk),
		.arst_n           (arst_n),
		.byte_req         (byte_req),
		.out_free         (out_free),
		.valid_s1         (valid_s1),
		.data_byte_s1     (data_byte_s1),
		.record_start_s1  (record_start_s1),
		.len_two_bytes_s1 (len_two_bytes_s1)
	);

	// advance the parser only when a possible result has somewhere to go
	assign step_fire = valid_s1 && out_free;

	susp_step u_step (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (step_fire),
		.byte_order    (byte_order_q),
		.data_byte     (data_byte_s1),
		.record_start  (record_start_s1),
		.len_two_bytes (len_two_bytes_s1),
		.res           (step_res)
	);

	// drive the result channel from its own register
	susp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (step_fire),
		.res      (step_res),
		.char_res (char_res),
		.out_free (out_free)
	);

endmodule

// File: rtl/core/susp_checker.sv
// Port-level checker for the string parser, bound to the top level.
// Depends on: spreadsheet_unicode_string_parser_core, susp_ifs.sv.
module susp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        char_valid,
	input logic [15:0] char_code,
	input logic        string_done
);

	// a held result stays until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(char_valid) && $stable(char_code)
			&& $stable(string_done))
		else $error("result payload changed while stalled");

	// a result without a character only ever closes a string, with a zero code
	a_end_marker: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> string_done && char_code == 16'd0)
		else $error("empty result that is not a string end");

	// the request side only backs up behind a stalled result
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("request side blocked without a stalled result");

endmodule

bind spreadsheet_unicode_string_parser_core susp_checker u_susp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (byte_req.ready),
	.out_valid   (char_res.valid),
	.out_ready   (char_res.ready),
	.char_valid  (char_res.char_valid),
	.char_code   (char_res.char_code),
	.string_done (char_res.string_done)
);

// File: tb/spreadsheet_unicode_string_parser_core_tb.sv
// Self-checking testbench for spreadsheet_unicode_string_parser_core.
// Depends on susp_pkg (phase codes, flag bit positions) and the channel interfaces in susp_ifs.sv.
// Streams string records through the parser and checks every character result against a predictor.
`timescale 1ns / 100ps

typedef struct packed {
	logic        char_valid;
	logic [15:0] char_code;
	logic        string_done;
} char_result_t;

// Tracks the parser state from accepted request bytes and holds the characters still due.
class string_tracker;
	bit                big_endian;
	int                errors;
	char_result_t      pending_chars[$];

	susp_pkg::phase_t  phase;
	bit [15:0]         char_target;
	bit [15:0]         chars_seen;
	bit [15:0]         run_count;
	bit                wide;
	bit                ext_on;
	bit                rich_on;
	bit [31:0]         ext_size;
	bit [32:0]         skip_left;
	bit [1:0]          field_idx;
	bit [23:0]         partial;

	function new();
		big_endian = 1'b0;
		errors = 0;
		phase = susp_pkg::PH_IDLE;
		clear_string();
	endfunction

	function void drop_field();
		field_idx = '0;
		partial = '0;
	endfunction

	function void clear_string();
		char_target = '0;
		chars_seen = '0;
		run_count = '0;
		wide = 1'b0;
		ext_on = 1'b0;
		rich_on = 1'b0;
		ext_size = '0;
		skip_left = '0;
		drop_field();
	endfunction

	// Join the stored leading bytes with the final byte of an nbytes-wide field.
	function bit [31:0] join_field(bit [7:0] last, int nbytes);
		if (big_endian)
			return {partial, last};
		return {8'h00, partial} | (32'(last) << (8 * (nbytes - 1)));
	endfunction

	function void keep_byte(bit [7:0] b);
		if (big_endian)
			partial = {partial[15:0], b};
		else
			partial = 24'({8'h00, partial} | (32'(b) << (8 * field_idx)));
		field_idx++;
	endfunction

	function void expect_char(bit cv, bit [15:0] code, bit done);
		char_result_t r;
		r.char_valid = cv;
		r.char_code = code;
		r.string_done = done;
		pending_chars.push_back(r);
	endfunction

	// Header done: extension bytes plus four per rich run get skipped. The sum
	// stays below the 33-bit ceiling, so no clamp is needed.
	function void start_body();
		skip_left = 33'(ext_size) + 33'({run_count, 2'b00});
		drop_field();
		if (char_target != 0)
			phase = susp_pkg::PH_CHARS;
		else if (skip_left != 0)
			phase = susp_pkg::PH_SKIP;
		else begin
			phase = susp_pkg::PH_IDLE;
			expect_char(1'b0, 16'h0000, 1'b1);
		end
	endfunction

	function void take_byte(bit [7:0] b, bit rs, bit two);
		bit [15:0] code;
		case (phase)
			susp_pkg::PH_LEN_HI: begin
				char_target = 16'(join_field(b, 2));
				drop_field();
				phase = susp_pkg::PH_FLAGS;
			end
			susp_pkg::PH_FLAGS: begin
				wide = b[susp_pkg::FLAG_WIDE_BIT];
				ext_on = b[susp_pkg::FLAG_EXT_BIT];
				rich_on = b[susp_pkg::FLAG_RICH_BIT];
				drop_field();
				if (rich_on)
					phase = susp_pkg::PH_RUNS;
				else if (ext_on)
					phase = susp_pkg::PH_EXT;
				else
					start_body();
			end
			susp_pkg::PH_RUNS: begin
				if (field_idx == 0)
					keep_byte(b);
				else begin
					run_count = 16'(join_field(b, 2));
					drop_field();
					if (ext_on)
						phase = susp_pkg::PH_EXT;
					else
						start_body();
				end
			end
			susp_pkg::PH_EXT: begin
				if (field_idx < 3)
					keep_byte(b);
				else begin
					ext_size = join_field(b, 4);
					start_body();
				end
			end
			susp_pkg::PH_CHARS: begin
				// continuation option byte: reload the width, drop any half character
				if (rs) begin
					wide = b[susp_pkg::FLAG_WIDE_BIT];
					drop_field();
				end else if (wide && field_idx == 0)
					keep_byte(b);
				else begin
					code = wide ? 16'(join_field(b, 2)) : {8'h00, b};
					drop_field();
					chars_seen++;
					if (chars_seen != char_target)
						expect_char(1'b1, code, 1'b0);
					else if (skip_left != 0) begin
						phase = susp_pkg::PH_SKIP;
						expect_char(1'b1, code, 1'b0);
					end else begin
						phase = susp_pkg::PH_IDLE;
						expect_char(1'b1, code, 1'b1);
					end
				end
			end
			susp_pkg::PH_SKIP: begin
				if (skip_left != 0)
					skip_left--;
				if (skip_left == 0) begin
					phase = susp_pkg::PH_IDLE;
					expect_char(1'b0, 16'h0000, 1'b1);
				end
			end
			default: begin
				// idle: this byte opens a new string header
				clear_string();
				if (two) begin
					keep_byte(b);
					phase = susp_pkg::PH_LEN_HI;
				end else begin
					char_target = {8'h00, b};
					phase = susp_pkg::PH_FLAGS;
				end
			end
		endcase
	endfunction

	function void match_char(logic cv, logic [15:0] code, logic done);
		char_result_t got;
		char_result_t want;
		got.char_valid = cv;
		got.char_code = code;
		got.string_done = done;
		if (pending_chars.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual char_valid=%0b char_code=%h string_done=%0b",
				$time, cv, code, done);
			errors++;
		end else begin
			want = pending_chars.pop_front();
			if (got !== want) begin
				$display("%0t: result mismatch, expected char_valid=%0b char_code=%h string_done=%0b",
					$time, want.char_valid, want.char_code, want.string_done);
				$display("%0t:   actual char_valid=%0b char_code=%h string_done=%0b",
					$time, cv, code, done);
				errors++;
			end
		end
	endfunction

	function void flush_missing();
		char_result_t want;
		while (pending_chars.size() != 0) begin
			want = pending_chars.pop_front();
			$display("%0t: missing result, expected char_valid=%0b char_code=%h string_done=%0b, actual none",
				$time, want.char_valid, want.char_code, want.string_done);
			errors++;
		end
	endfunction

	function int pending();
		return pending_chars.size();
	endfunction
endclass

module spreadsheet_unicode_string_parser_core_tb;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int N_PHASES       = 6;
	localparam int PHASE_ITEMS    = 317;
	localparam int DRAIN_LIMIT    = 5000;
	// margin waited after the drain, once no result is still expected
	localparam int SETTLE_CYCLES  = 8;
	localparam int HOLD_PERIOD    = 6000;
	localparam int HOLD_START     = 1000;
	localparam int HOLD_CYCLES    = 300;
	localparam int RX_MODE_CYCLES = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	susp_byte_if byte_bus();
	susp_char_if char_bus();

	string_tracker tracker = new();

	int items_sent;
	int burst_left;
	bit gaps_on;
	int cycle_count;

	spreadsheet_unicode_string_parser_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_req (byte_bus),
		.char_res (char_bus),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one request at the falling edge and hold it until the parser takes it.
	// The sender runs in bursts; between bursts, when gaps are on, drop valid for a random gap.
	task automatic send_byte(input logic [7:0] b, input logic rs, input logic two);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				@(negedge clk);
				byte_bus.valid <= 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		byte_bus.valid <= 1'b1;
		byte_bus.data_byte <= b;
		byte_bus.record_start <= rs;
		byte_bus.len_two_bytes <= two;
		do @(posedge clk); while (!byte_bus.ready);
		tracker.take_byte(b, rs, two);
		items_sent++;
	endtask

	// Send a multi-byte header field in the configured byte order. record_start
	// and len_two_bytes are ignored here, so randomize them.
	task automatic send_field(input logic [31:0] value, input int nbytes);
		for (int i = 0; i < nbytes; i++)
			send_byte(8'(value >> (8 * (tracker.big_endian ? nbytes - 1 - i : i))),
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// One well-formed string with random content. The body mixes in continuation
	// option bytes, some of them splitting a wide character.
	task automatic send_string();
		logic        two;
		logic        wide;
		logic [7:0]  flags;
		logic [7:0]  option;
		logic [15:0] count;
		int          pick;
		int          runs;
		int          ext_size;
		int          left;
		int          skip_bytes;
		two = 1'($urandom_range(0, 1));
		pick = $urandom_range(0, 63);
		if (pick < 8)
			count = 16'h0000;
		else if (pick == 8)
			count = two ? 16'($urandom_range(256, 320)) : 16'($urandom_range(240, 255));
		else
			count = 16'($urandom_range(1, 16));
		flags = 8'($urandom());
		runs = $urandom_range(0, 3);
		ext_size = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 9);

		if (two) begin
			send_byte(tracker.big_endian ? count[15:8] : count[7:0], 1'($urandom_range(0, 1)), 1'b1);
			send_byte(tracker.big_endian ? count[7:0] : count[15:8],
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else
			send_byte(count[7:0], 1'($urandom_range(0, 1)), 1'b0);
		send_byte(flags, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		if (flags[susp_pkg::FLAG_RICH_BIT])
			send_field(32'(runs), 2);
		if (flags[susp_pkg::FLAG_EXT_BIT])
			send_field(32'(ext_size), 4);

		wide = flags[susp_pkg::FLAG_WIDE_BIT];
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 19) == 0) begin
				option = 8'($urandom());
				send_byte(option, 1'b1, 1'($urandom_range(0, 1)));
				wide = option[susp_pkg::FLAG_WIDE_BIT];
			end else if (wide) begin
				send_byte(8'($urandom()), 1'b0, 1'($urandom_range(0, 1)));
				if ($urandom_range(0, 19) == 0) begin
					// break the wide character: its first half gets dropped
					option = 8'($urandom());
					send_byte(option, 1'b1, 1'($urandom_range(0, 1)));
					wide = option[susp_pkg::FLAG_WIDE_BIT];
				end else begin
					send_byte(8'($urandom()), 1'b0, 1'($urandom_range(0, 1)));
					left--;
				end
			end else begin
				send_byte(8'($urandom()), 1'b0, 1'($urandom_range(0, 1)));
				left--;
			end
		end

		skip_bytes = (flags[susp_pkg::FLAG_RICH_BIT] ? 4 * runs : 0)
			+ (flags[susp_pkg::FLAG_EXT_BIT] ? ext_size : 0);
		repeat (skip_bytes)
			send_byte(8'($urandom()), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
	endtask

	// Drop valid, wait for every expected character, then let the pipeline empty.
	task automatic settle_results();
		int spins;
		@(negedge clk);
		byte_bus.valid <= 1'b0;
		for (spins = 0; spins < DRAIN_LIMIT && tracker.pending() != 0; spins++)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		tracker.flush_missing();
	endtask

	// Change byte order only while the parser sits idle between strings.
	task automatic write_byte_order(input logic big);
		settle_results();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= big;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.big_endian = big;
	endtask

	// Result side: stall on a pattern that is redrawn every RX_MODE_CYCLES, and
	// now and then hold ready low long enough for the parser to back up and stall
	// the request side.
	initial begin
		int rx_cycle;
		int hold_left;
		int mode;
		int period;
		rx_cycle = 0;
		hold_left = 0;
		mode = 0;
		period = 3;
		char_bus.ready <= 1'b0;
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle % RX_MODE_CYCLES == 0) begin
				mode = $urandom_range(0, 3);
				period = $urandom_range(2, 5);
			end
			if (rx_cycle % HOLD_PERIOD == HOLD_START)
				hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				char_bus.ready <= 1'b0;
			end else begin
				case (mode)
					0: char_bus.ready <= 1'b1;
					1: char_bus.ready <= 1'($urandom_range(0, 1));
					2: char_bus.ready <= ($urandom_range(0, 6) != 0);
					default: char_bus.ready <= (rx_cycle % period != 0);
				endcase
			end
		end
	end

	// Check every character handed over on the result channel.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && char_bus.valid && char_bus.ready)
				tracker.match_char(char_bus.char_valid, char_bus.char_code, char_bus.string_done);
		end
	end

	// Hard stop in case the parser hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** spreadsheet_unicode_string_parser_core: FAILED **");
		$finish;
	end

	initial begin
		logic [9:0] directed_bytes[$];
		int         phase_end;
		// each entry: {record_start, len_two_bytes, data_byte}, little endian order
		directed_bytes = '{
			10'h202, 10'h000, 10'h000, 10'h0FF,          // two narrow chars at the byte extremes
			10'h000, 10'h0F2,                            // empty string, nothing to skip
			10'h101, 10'h300, 10'h00D,                   // two-byte count of 1, wide, rich, ext
			10'h201, 10'h000,                            // one rich run
			10'h002, 10'h000, 10'h000, 10'h000,          // two extension bytes
			10'h034, 10'h201, 10'h0FF, 10'h0FF,          // half char dropped by option byte, then 0xFFFF
			10'h2AA, 10'h155, 10'h000, 10'h3FF, 10'h080, 10'h07F  // skipped bytes, last one ends it
		};

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		byte_bus.valid <= 1'b0;
		byte_bus.data_byte <= 8'h00;
		byte_bus.record_start <= 1'b0;
		byte_bus.len_two_bytes <= 1'b0;
		items_sent = 0;
		burst_left = 0;
		gaps_on = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed strings back to back, no sender gaps.
		foreach (directed_bytes[i])
			send_byte(directed_bytes[i][7:0], directed_bytes[i][9], directed_bytes[i][8]);

		// Random strings; flip the byte order between phases, the first phase
		// keeps the reset value.
		for (int ph = 0; ph < N_PHASES; ph++) begin
			if (ph != 0)
				write_byte_order(1'(ph % 2));
			gaps_on = (ph != 2);
			burst_left = 0;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_string();
		end

		settle_results();
		if (tracker.errors == 0)
			$display("** spreadsheet_unicode_string_parser_core: PASSED **");
		else
			$display("** spreadsheet_unicode_string_parser_core: FAILED **");
		$finish;
	end

endmodule
